>>> hdl/assert_macros.svh
// Assertion macros shared by the timer queue modules.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define DTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dtq_pkg.sv
// Shared constants, codes and control structs of the deadline timer queue.
// No dependencies.
package dtq_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int HANDLE_W = 4;
  localparam int TIME_W   = 63;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 136;

  localparam logic [TIME_W-1:0] MIN_ARM_DELAY = 63'd100;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] KIND_ADDED   = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic              load;
    logic              sel_step;
    logic              commit;
    logic              min_step;
    logic              calc;
    logic              delay;
    logic              emit;
    logic [SLOT_W-1:0] idx;
  } dtq_cmd_t;

  typedef struct packed {
    logic sel_found;
    logic out_free;
    logic emit_last;
  } dtq_sts_t;

endpackage

>>> hdl/dtq_ctrl.sv
// Sequencer of the timer queue: walks the slot scans and result emission.
// Depends on dtq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_command,
  output logic     in_tready,
  input  dtq_sts_t sts,
  output dtq_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEL    = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_MIN    = 3'd3;
  localparam logic [2:0] S_CALC   = 3'd4;
  localparam logic [2:0] S_DELAY  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              idx_last;

  assign idx_last  = (idx_r == SLOT_W'(SLOTS - 1));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = (in_command == CMD_TICK) ? S_SEL : S_MIN;
        end
      end
      S_SEL: begin
        cmd.sel_step = 1'b1;
        idx_nxt      = idx_r + 1'b1;
        if (idx_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // One pass finds the next expired timer; stop when a pass finds none.
        cmd.commit = 1'b1;
        idx_nxt    = '0;
        state_nxt  = sts.sel_found ? S_SEL : S_MIN;
      end
      S_MIN: begin
        cmd.min_step = 1'b1;
        idx_nxt      = idx_r + 1'b1;
        if (idx_last) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DELAY;
      end
      S_DELAY: begin
        cmd.delay = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `DTQ_ASSERT(a_accept_leaves_idle, in_tvalid && in_tready |=> state_r != S_IDLE, "busy after accept")
  `DTQ_ASSERT(a_scan_starts_at_zero, $rose(cmd.min_step) |-> idx_r == '0, "scan misaligned")
  `DTQ_ASSERT(a_emit_needs_room, cmd.emit |-> sts.out_free, "emit into full output")

endmodule

>>> hdl/dtq_dp.sv
// Datapath of the timer queue: slot table, scan units and result register.
// Depends on dtq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dtq_dp
  import dtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtq_cmd_t              cmd,
  output dtq_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  logic                tick_r;
  logic [TIME_W-1:0]   exp_in_r, iv_in_r, now_r;
  logic [SLOTS-1:0]    valid_r, done_r;
  logic [TIME_W-1:0]   exp_r [SLOTS];
  logic [TIME_W-1:0]   ivl_r [SLOTS];
  logic [SLOT_W-1:0]   order_r [SLOTS];
  logic [CNT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]   ptr_r;
  logic                found_r;
  logic [TIME_W-1:0]   best_r, best_iv_r;
  logic [SLOT_W-1:0]   best_h_r;
  logic                any_r, free_found_r;
  logic [TIME_W-1:0]   min_r;
  logic [SLOT_W-1:0]   free_h_r;
  logic                res_valid_r, res_changed_r;
  logic [TIME_W-1:0]   res_when_r, delay_r;
  logic                out_valid_r, out_last_r;
  logic [1:0]          out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                cur_v, cur_done;
  logic [TIME_W-1:0]   cur_e, cur_iv;
  logic [TIME_W:0]     rearm_sum, diff;
  logic [TIME_W-1:0]   rearm_val;
  logic                add_changed;
  logic                emit_last;
  logic [1:0]          e_kind;
  logic [HANDLE_W-1:0] e_handle;
  logic                e_changed;

  assign cur_v    = valid_r[cmd.idx];
  assign cur_done = done_r[cmd.idx];
  assign cur_e    = exp_r[cmd.idx];
  assign cur_iv   = ivl_r[cmd.idx];

  assign rearm_sum = {1'b0, now_r} + {1'b0, best_iv_r};
  assign rearm_val = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];
  assign diff      = {1'b0, res_when_r} - {1'b0, now_r};

  assign add_changed = !any_r || (exp_in_r < min_r);

  always_comb begin
    e_kind    = KIND_EXPIRED;
    e_handle  = HANDLE_W'(order_r[ptr_r]);
    e_changed = 1'b0;
    emit_last = ((CNT_W'(ptr_r) + 1'b1) == cnt_r);
    if (!tick_r) begin
      emit_last = 1'b1;
      if (free_found_r) begin
        e_kind    = KIND_ADDED;
        e_handle  = HANDLE_W'(free_h_r);
        e_changed = res_changed_r;
      end else begin
        e_kind   = KIND_FULL;
        e_handle = '0;
      end
    end else if (cnt_r == '0) begin
      emit_last = 1'b1;
      e_kind    = KIND_NONE;
      e_handle  = '0;
    end
  end

  assign sts.sel_found = found_r;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.emit_last = emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      done_r       <= '0;
      cnt_r        <= '0;
      ptr_r        <= '0;
      found_r      <= 1'b0;
      any_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !cmd.emit) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        tick_r       <= in_tuser;
        exp_in_r     <= in_tdata[62:0];
        iv_in_r      <= in_tdata[125:63];
        now_r        <= in_tdata[188:126];
        done_r       <= '0;
        cnt_r        <= '0;
        ptr_r        <= '0;
        found_r      <= 1'b0;
        any_r        <= 1'b0;
        free_found_r <= 1'b0;
        min_r        <= '0;
      end
      if (cmd.sel_step) begin
        // Strict compare keeps the lower handle on equal deadlines.
        if (cur_v && !cur_done && (cur_e <= now_r) && (!found_r || cur_e < best_r)) begin
          found_r   <= 1'b1;
          best_r    <= cur_e;
          best_iv_r <= cur_iv;
          best_h_r  <= cmd.idx;
        end
      end
      if (cmd.commit) begin
        found_r <= 1'b0;
        if (found_r) begin
          order_r[cnt_r[SLOT_W-1:0]] <= best_h_r;
          cnt_r            <= cnt_r + 1'b1;
          done_r[best_h_r] <= 1'b1;
          if (best_iv_r != '0) begin
            exp_r[best_h_r] <= rearm_val;
          end else begin
            valid_r[best_h_r] <= 1'b0;
          end
        end
      end
      if (cmd.min_step) begin
        if (cur_v && (!any_r || cur_e < min_r)) begin
          any_r <= 1'b1;
          min_r <= cur_e;
        end
        if (!cur_v && !free_found_r) begin
          free_found_r <= 1'b1;
          free_h_r     <= cmd.idx;
        end
      end
      if (cmd.calc) begin
        res_changed_r <= 1'b0;
        res_valid_r   <= any_r;
        res_when_r    <= min_r;
        if (!tick_r && free_found_r) begin
          valid_r[free_h_r] <= 1'b1;
          exp_r[free_h_r]   <= exp_in_r;
          ivl_r[free_h_r]   <= iv_in_r;
          res_changed_r     <= add_changed;
          res_valid_r       <= 1'b1;
          res_when_r        <= add_changed ? exp_in_r : min_r;
        end
      end
      if (cmd.delay) begin
        if (res_valid_r && (res_when_r > now_r) && (diff[TIME_W-1:0] > MIN_ARM_DELAY)) begin
          delay_r <= diff[TIME_W-1:0];
        end else begin
          delay_r <= MIN_ARM_DELAY;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= e_kind;
        out_last_r  <= emit_last;
        out_data_r  <= {4'b0, delay_r, res_when_r, res_valid_r, e_changed, e_handle};
        ptr_r       <= ptr_r + 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `DTQ_ASSERT(a_cnt_bounded, cnt_r <= CNT_W'(SLOTS), "expired count overflow")
  `DTQ_ASSERT_NEXT(a_commit_marks_done, cmd.commit && found_r, done_r[$past(best_h_r)], "reported slot not marked")
  `DTQ_ASSERT_NEXT(a_add_sets_valid, cmd.calc && !tick_r && free_found_r, valid_r[$past(free_h_r)], "added slot not valid")

endmodule

>>> hdl/deadline_timer_queue.sv
// Deadline timer queue: a 16-slot table of armed timers with ordered expiry.
// Channels: in_* carries one command item. in_tuser is the command (0 add,
// 1 tick); in_tdata holds expiry_time, repeat_interval and current_time.
// out_* carries result items; out_tuser is the kind, out_tlast marks the
// final result of an input item.
// An add scans all slots once for the earliest deadline and a free slot,
// then steps through the calc and delay states before its result.
// A tick runs one slot scan per expired timer plus one empty scan, each
// closed by a commit state, then the minimum scan. Its results then come
// out at one result per cycle while the receiver takes them.
// One item is processed at a time; in_tready is high only between items.
// The last result may still wait in the output register while the next
// item is taken. If the receiver stalls, emission pauses with it.
// Reset clears every slot's valid bit and the output register's valid bit.
// Depends on dtq_pkg, dtq_ctrl and dtq_dp.
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // expiry_time [62:0], repeat_interval [125:63], current_time [188:126]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // timer_handle [3:0], earliest_changed [4], next_valid [5],
  // next_expiration [68:6], arm_delay [131:69]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  dtq_cmd_t cmd;
  dtq_sts_t sts;

  dtq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser),
    .in_tready  (in_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dtq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/dtq_result_monitor.sv
`timescale 1ns / 100ps
// Result monitor for the deadline timer queue: keeps its own timer table,
// predicts the results of every accepted command item and compares them.
// Depends on dtq_pkg.
module dtq_result_monitor
  import dtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    results_owed
);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic                earliest_changed;
    logic                next_valid;
    logic [TIME_W-1:0]   next_expiration;
    logic [TIME_W-1:0]   arm_delay;
    logic                last;
  } timer_event_t;

  timer_event_t      timer_events_due[$];
  logic              armed[SLOTS];
  logic [TIME_W-1:0] deadline[SLOTS];
  logic [TIME_W-1:0] period[SLOTS];

  initial fail_count = 0;
  assign results_owed = timer_events_due.size();

  function automatic logic earliest_deadline(output logic [TIME_W-1:0] when);
    logic found;
    found = 1'b0;
    when  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (armed[i] && (!found || deadline[i] < when)) begin
        when  = deadline[i];
        found = 1'b1;
      end
    end
    return found;
  endfunction

  // Appends one result; the table summary reflects the state after the item.
  task automatic queue_event(input logic [1:0] kind, input int slot, input logic changed,
                             input logic last, input logic [TIME_W-1:0] now);
    timer_event_t ev;
    logic [TIME_W-1:0] when;
    ev.kind             = kind;
    ev.handle           = slot[HANDLE_W-1:0];
    ev.earliest_changed = changed;
    ev.next_valid       = earliest_deadline(when);
    ev.next_expiration  = when;
    ev.arm_delay        = MIN_ARM_DELAY;
    if (ev.next_valid && when > now && when - now > MIN_ARM_DELAY)
      ev.arm_delay = when - now;
    ev.last = last;
    timer_events_due.push_back(ev);
  endtask

  task automatic advance_timer_table(input logic cmd, input logic [TIME_W-1:0] expiry,
                                     input logic [TIME_W-1:0] interval,
                                     input logic [TIME_W-1:0] now);
    int order[SLOTS];
    int n;
    int j;
    int free_slot;
    logic any;
    logic [TIME_W-1:0] best;
    n = 0;
    free_slot = -1;
    if (cmd == CMD_ADD) begin
      any = earliest_deadline(best);
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!armed[i]) free_slot = i;
      if (free_slot < 0) begin
        queue_event(KIND_FULL, 0, 1'b0, 1'b1, now);
      end else begin
        armed[free_slot]    = 1'b1;
        deadline[free_slot] = expiry;
        period[free_slot]   = interval;
        queue_event(KIND_ADDED, free_slot, !any || expiry < best, 1'b1, now);
      end
    end else begin
      // Stable insertion by deadline keeps ties in handle order.
      for (int i = 0; i < SLOTS; i++) begin
        if (armed[i] && deadline[i] <= now) begin
          j = n;
          while (j > 0 && deadline[order[j-1]] > deadline[i]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = i;
          n++;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (period[order[i]] != '0)
          deadline[order[i]] = (period[order[i]] > TIME_MAX - now) ? TIME_MAX
                                                                   : now + period[order[i]];
        else
          armed[order[i]] = 1'b0;
      end
      if (n == 0)
        queue_event(KIND_NONE, 0, 1'b0, 1'b1, now);
      for (int i = 0; i < n; i++)
        queue_event(KIND_EXPIRED, order[i], 1'b0, i == n - 1, now);
    end
  endtask

  task automatic report(input string field, input logic [TIME_W-1:0] got,
                        input logic [TIME_W-1:0] want);
    if (fail_count < 30)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    timer_event_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) armed[i] = 1'b0;
      timer_events_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        advance_timer_table(in_tuser, in_tdata[62:0], in_tdata[125:63], in_tdata[188:126]);
      if (out_tvalid && out_tready) begin
        if (timer_events_due.size() == 0) begin
          report("unexpected result item", out_tuser, 0);
        end else begin
          want = timer_events_due.pop_front();
          if (out_tuser != want.kind) report("kind", out_tuser, want.kind);
          if (out_tdata[3:0] != want.handle) report("timer_handle", out_tdata[3:0], want.handle);
          if (out_tdata[4] != want.earliest_changed)
            report("earliest_changed", out_tdata[4], want.earliest_changed);
          if (out_tdata[5] != want.next_valid) report("next_valid", out_tdata[5], want.next_valid);
          if (out_tdata[68:6] != want.next_expiration)
            report("next_expiration", out_tdata[68:6], want.next_expiration);
          if (out_tdata[131:69] != want.arm_delay)
            report("arm_delay", out_tdata[131:69], want.arm_delay);
          if (out_tlast != want.last) report("last", out_tlast, want.last);
        end
      end
    end
  end

endmodule

>>> tb/deadline_timer_queue_tb.sv
`timescale 1ns / 100ps
// Testbench top for the deadline timer queue: drives command items and
// receiver stalls, and gives the verdict from the result monitor's count.
// Depends on dtq_pkg, deadline_timer_queue and dtq_result_monitor.
module deadline_timer_queue_tb;
  import dtq_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
  localparam int                CYCLE_CAP  = 1000000;
  localparam int                RANDOM_ITEMS = 310;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    results_owed;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    cycles = 0;
  logic [TIME_W-1:0]     clock_now = '0;

  deadline_timer_queue u_top (.*);

  dtq_result_monitor u_mon (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycles >= CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_command(input logic cmd, input logic [TIME_W-1:0] expiry,
                              input logic [TIME_W-1:0] interval,
                              input logic [TIME_W-1:0] now);
    int gap;
    logic ready_seen;
    gap = 0;
    ready_seen = 1'b0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, now, interval, expiry};
    in_tvalid <= 1'b1;
    // in_tready only changes at rising edges, so the falling edge shows the
    // value that the next rising edge will see.
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end
  endtask

  function automatic logic [TIME_W-1:0] wide_random();
    return TIME_W'({$urandom, $urandom});
  endfunction

  initial begin
    int pick;
    logic [TIME_W-1:0] t;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, close and past deadlines, equal deadlines, full table,
    // ordered expiry with ties, re-arm saturation.
    send_command(CMD_TICK, '0, '0, '0);
    send_command(CMD_ADD, TIME_W'(50), '0, '0);
    send_command(CMD_ADD, TIME_W'(50), '0, '0);
    send_command(CMD_ADD, TIME_MAX, TIME_MAX, '0);
    send_command(CMD_ADD, TIME_W'(1000), TIME_W'(1), '0);
    send_command(CMD_ADD, '0, '0, TIME_W'(10));
    for (int i = 0; i < 11; i++)
      send_command(CMD_ADD, TIME_W'(200 + i * 7), '0, TIME_W'(20));
    send_command(CMD_ADD, TIME_W'(5), '0, TIME_W'(30));
    send_command(CMD_TICK, '0, '0, TIME_W'(60));
    send_command(CMD_TICK, '0, '0, TIME_MAX);
    send_command(CMD_TICK, '0, '0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 40) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // Let all owed results drain completely once before carrying on.
      if (n == 150) begin
        in_tvalid <= 1'b0;
        while (results_owed != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      clock_now = clock_now + TIME_W'($urandom_range(300));
      if (pick < 5) begin
        t = wide_random();
        send_command(1'($urandom_range(1)), wide_random(), pick < 2 ? wide_random() : '0, t);
        if (t > clock_now) clock_now = t;
      end else if (pick < 60) begin
        t = clock_now + TIME_W'($urandom_range(700)) - TIME_W'(100);
        send_command(CMD_ADD, t,
                     ($urandom_range(3) == 0) ? TIME_W'($urandom_range(1, 500)) : '0,
                     clock_now);
      end else begin
        send_command(CMD_TICK, TIME_W'($urandom), TIME_W'($urandom), clock_now);
      end
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (results_owed != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
